>>> hdl/lhm_pkg.sv
package lhm_pkg;

    // field widths of the transaction payloads
    localparam int ACT_W      = 2;
    localparam int LAT_W      = 24;
    localparam int BYTE_W     = 11;
    localparam int CNT_W      = 32;
    localparam int LSUM_W     = 56;
    localparam int EDGE_OUT_W = 15;

    // default histogram geometry
    localparam int BUCKETS_DEF   = 128;
    localparam int BUCKET_US_DEF = 250;

    // 99th percentile as a ratio
    localparam int PCT_NUM = 99;
    localparam int PCT_DEN = 100;
    localparam int X_W     = CNT_W + $clog2(PCT_DEN);

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_RECORD = 2'd1,
        ACT_REPORT = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_IDX,
        S_WR,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [LAT_W-1:0]    latency_us;
        logic [BYTE_W-1:0]   sent_bytes;
        logic [BYTE_W-1:0]   received_bytes;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]      frame_total;
        logic [CNT_W-1:0]      sent_total;
        logic [CNT_W-1:0]      received_total;
        logic [LAT_W-1:0]      latency_min;
        logic [LAT_W-1:0]      latency_max;
        logic [LSUM_W-1:0]     latency_sum;
        logic [EDGE_OUT_W-1:0] p99_edge_us;
        logic                  p99_saturated;
    } t_out;

endpackage

>>> hdl/latency_histogram_monitor_unit.sv
// Latency histogram monitor
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction per
// action: clear, record one latency sample with byte counts, report the 99th
// percentile, or a no-op. Every input transaction yields exactly one output
// transaction (o_out_valid / i_out_ready / o_out_data) carrying the running totals
// after the action, plus the percentile edge on report.
// One transaction is worked on at a time; the steps from acceptance until the result
// is valid at the output register:
//   no-op or report with no frames: output load only
//   record: index multiply, bucket memory read, write back, output load
//   clear: the one-entry-per-cycle sweep of the bucket memory, then output load
//   report: a walk from bucket 0 up to the bucket where the percentile lands, then output load;
//   the walk reads one bucket per cycle from the single read port
// After reset the bucket memory is cleared by a sweep during which
// o_in_ready is low.
// A stalled receiver holds the result in the output register; the next transaction
// is still taken and worked on, and its result waits until the register frees.
module latency_histogram_monitor_unit
    import lhm_pkg::*;
#(
    parameter int BUCKETS   = BUCKETS_DEF,
    parameter int BUCKET_US = BUCKET_US_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = $clog2(BUCKETS);
    localparam int EW = $clog2(BUCKETS * BUCKET_US + 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(BUCKETS - 1);
    localparam logic [AW-1:0] ADDR_LAST_CMP = AW'(BUCKETS - 2);
    localparam logic [31:0] EDGE_LAST = 32'((BUCKETS - 1) * BUCKET_US);

    t_state r_state, n_state;

    logic             in_fire;
    logic             out_load;
    logic             mem_wr_en;
    logic [CNT_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [CNT_W-1:0] mem_rd_data;
    logic [AW-1:0]    bucket_idx;
    logic             walk_hit;
    logic             walk_sat;
    logic [X_W:0]     seen_scaled;

    logic [AW-1:0]     r_addr;
    logic [CNT_W-1:0]  r_frames;
    logic [CNT_W-1:0]  r_sent;
    logic [CNT_W-1:0]  r_recv;
    logic [LAT_W-1:0]  r_min;
    logic [LAT_W-1:0]  r_max;
    logic [LSUM_W-1:0] r_lsum;

    logic             r_issue_on;
    logic [EW-1:0]    r_issue_edge;
    logic             r_p1_vld;
    logic [EW-1:0]    r_p1_edge;
    logic             r_p1_last;
    logic             r_p2_vld;
    logic [EW-1:0]    r_p2_edge;
    logic             r_p2_last;
    logic [CNT_W-1:0] r_seen;
    logic [X_W-1:0]   r_x;
    logic [EW-1:0]    r_res_edge;
    logic             r_res_sat;

    logic r_out_valid;
    t_out r_out;

    logic [EW+EDGE_OUT_W-1:0] edge_ext;

    assign in_fire = i_in_valid && o_in_ready;

    // bucket store
    lhm_bucket_mem #(
        .DEPTH (BUCKETS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // latency to bucket index
    lhm_bucket_index #(
        .BUCKETS   (BUCKETS),
        .BUCKET_US (BUCKET_US),
        .AW        (AW)
    ) u_index (
        .i_clk     (i_clk),
        .i_load    (in_fire && (i_in_data.action == ACT_RECORD)),
        .i_latency (i_in_data.latency_us),
        .o_index   (bucket_idx)
    );

    // percentile compare: seen >= floor(99 * frames / 100) as 100 * seen + 99 >= 99 * frames
    always_comb begin
        seen_scaled = (X_W + 1)'(r_seen) * (X_W + 1)'(PCT_DEN) + (X_W + 1)'(PCT_DEN - 1);
        walk_hit    = r_p2_vld && (seen_scaled >= (X_W + 1)'(r_x));
        walk_sat    = r_p2_vld && !walk_hit && r_p2_last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_addr == ADDR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_data.action)
                        ACT_CLEAR:  n_state = S_CLEAR;
                        ACT_RECORD: n_state = S_IDX;
                        ACT_REPORT: n_state = (r_frames == '0) ? S_DONE : S_WALK;
                        ACT_NONE:   n_state = S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_addr == ADDR_LAST) n_state = S_DONE;
            end
            S_IDX:  n_state = S_WR;
            S_WR:   n_state = S_DONE;
            S_WALK: begin
                if (walk_hit || walk_sat) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_addr;
        out_load    = 1'b0;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                mem_wr_en = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_IDX: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = bucket_idx;
            end
            S_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data + CNT_W'(1);
            end
            S_WALK: begin
                mem_rd_en = r_issue_on;
            end
            S_DONE: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // memory address counter: sweep, record index, walk issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (r_state == S_INIT || r_state == S_CLEAR) begin
            r_addr <= r_addr + AW'(1);
        end else if (in_fire) begin
            r_addr <= '0;
        end else if (r_state == S_IDX) begin
            r_addr <= bucket_idx;
        end else if (r_state == S_WALK && r_issue_on) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    // running totals, min and max
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
            r_sent   <= '0;
            r_recv   <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_lsum   <= '0;
        end else if (in_fire && i_in_data.action == ACT_CLEAR) begin
            r_frames <= '0;
            r_sent   <= '0;
            r_recv   <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_lsum   <= '0;
        end else if (in_fire && i_in_data.action == ACT_RECORD) begin
            r_frames <= r_frames + CNT_W'(1);
            r_sent   <= r_sent + CNT_W'(i_in_data.sent_bytes);
            r_recv   <= r_recv + CNT_W'(i_in_data.received_bytes);
            r_lsum   <= r_lsum + LSUM_W'(i_in_data.latency_us);
            if (i_in_data.latency_us < r_min) r_min <= i_in_data.latency_us;
            if (i_in_data.latency_us > r_max) r_max <= i_in_data.latency_us;
        end
    end

    // percentile walk: issue read, accumulate, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_on <= 1'b0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_res_sat  <= 1'b0;
            r_res_edge <= '0;
        end else if (in_fire) begin
            r_issue_on   <= (i_in_data.action == ACT_REPORT);
            r_issue_edge <= EW'(BUCKET_US);
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_seen       <= '0;
            r_x          <= X_W'(r_frames) * X_W'(PCT_NUM);
            r_res_edge   <= '0;
            r_res_sat    <= 1'b0;
        end else if (r_state == S_WALK) begin
            // issue stage
            r_p1_vld <= r_issue_on;
            if (r_issue_on) begin
                r_p1_edge    <= r_issue_edge;
                r_p1_last    <= (r_addr == ADDR_LAST_CMP);
                r_issue_edge <= r_issue_edge + EW'(BUCKET_US);
                if (r_addr == ADDR_LAST_CMP) r_issue_on <= 1'b0;
            end
            // accumulate stage
            r_p2_vld <= r_p1_vld;
            if (r_p1_vld) begin
                r_seen    <= r_seen + mem_rd_data;
                r_p2_edge <= r_p1_edge;
                r_p2_last <= r_p1_last;
            end
            // compare stage result
            if (walk_hit || walk_sat) begin
                r_res_edge <= r_p2_edge;
                r_res_sat  <= walk_sat;
            end
        end
    end

    assign edge_ext = (EW + EDGE_OUT_W)'(r_res_edge);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.frame_total    <= r_frames;
            r_out.sent_total     <= r_sent;
            r_out.received_total <= r_recv;
            r_out.latency_min    <= r_min;
            r_out.latency_max    <= r_max;
            r_out.latency_sum    <= r_lsum;
            r_out.p99_edge_us    <= edge_ext[EDGE_OUT_W-1:0];
            r_out.p99_saturated  <= r_res_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a recorded sample lies within the tracked min and max
    a_record_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.action == ACT_RECORD) |=>
            (r_min <= $past(i_in_data.latency_us)) && (r_max >= $past(i_in_data.latency_us)))
        else $error("min or max not updated by record");

    // a saturated report always carries the last bucket edge
    a_sat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.p99_saturated) |->
            (o_out_data.p99_edge_us == EDGE_LAST[EDGE_OUT_W-1:0]))
        else $error("saturated report with wrong edge");

    // the walk only reads the bucket store
    a_walk_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !mem_wr_en)
        else $error("bucket write during percentile walk");

    // clear empties the frame counter
    a_clear_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.action == ACT_CLEAR) |=> (r_frames == '0))
        else $error("frame counter not cleared");

endmodule

>>> hdl/lhm_bucket_mem.sv
module lhm_bucket_mem
    import lhm_pkg::*;
#(
    parameter int DEPTH = BUCKETS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [CNT_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [CNT_W-1:0] o_rd_data
);

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/lhm_bucket_index.sv
module lhm_bucket_index
    import lhm_pkg::*;
#(
    parameter int BUCKETS   = BUCKETS_DEF,
    parameter int BUCKET_US = BUCKET_US_DEF,
    parameter int AW        = $clog2(BUCKETS)
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [LAT_W-1:0] i_latency,
    output logic [AW-1:0]    o_index
);

    // reciprocal of the bucket width, scaled so the estimate is short by at most one
    localparam int          SHIFT      = LAT_W + $clog2(BUCKET_US);
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / BUCKET_US;
    localparam int          RW         = LAT_W + 1;
    localparam logic [RW-1:0] RECIP    = RECIP_FULL[RW-1:0];
    localparam int          PW         = LAT_W + RW;
    localparam int          BW         = $clog2(BUCKET_US + 1);
    localparam int          QB_W       = RW + BW;

    logic [PW-1:0]    r_prod;
    logic [LAT_W-1:0] r_lat;
    logic [RW-1:0]    q_est;
    logic [QB_W-1:0]  q_back;
    logic [QB_W-1:0]  q_rem;
    logic [RW-1:0]    q_fix;

    // reciprocal multiply, registered
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PW'(i_latency) * PW'(RECIP);
            r_lat  <= i_latency;
        end
    end

    // remainder check corrects the estimate, then clamp into the last bucket
    always_comb begin
        q_est  = RW'(r_prod >> SHIFT);
        q_back = QB_W'(q_est) * QB_W'(BUCKET_US);
        q_rem  = QB_W'(r_lat) - q_back;
        q_fix  = (q_rem >= QB_W'(BUCKET_US)) ? q_est + RW'(1) : q_est;
        if (q_fix >= RW'(BUCKETS)) begin
            o_index = AW'(BUCKETS - 1);
        end else begin
            o_index = q_fix[AW-1:0];
        end
    end

endmodule
